[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL files.
// Each macro takes a label, the clock, the active-low reset, the property terms and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) else $error(msg);

`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rstn, cond, msg)
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

[hw/rtl/tvpa_pkg.sv]
package tvpa_pkg;

    localparam int VOL_W   = 12;
    localparam int PRES_W  = 10;
    localparam int SP_W    = 11;
    localparam int STEP_W  = 7;
    localparam int CFG_W   = 12;
    localparam int IDX_W   = 3;

    localparam int MIN_STEP_DEF = 2;
    localparam int MAX_STEP_DEF = 16;

    // Register indexes of the configuration port.
    typedef enum logic [IDX_W-1:0] {
        REG_RELATIVE_CONVENTION = 3'd0,
        REG_FLOOR_FROM_SETTING  = 3'd1,
        REG_TARGET_VOLUME       = 3'd2,
        REG_MAX_PRESSURE        = 3'd3,
        REG_PEEP_LEVEL          = 3'd4,
        REG_PRESSURE_SETTING    = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic              relative_convention;
        logic              floor_from_setting;
        logic [VOL_W-1:0]  target_volume;
        logic [PRES_W-1:0] max_pressure;
        logic [PRES_W-1:0] peep_level;
        logic [PRES_W-1:0] pressure_setting;
    } cfg_t;

    typedef struct packed {
        logic [VOL_W-1:0] measured_volume;
        logic             high_pressure_alarm;
        logic             restart;
    } item_t;

endpackage

[hw/rtl/tvpa_cfg_regs.sv]
module tvpa_cfg_regs (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [tvpa_pkg::IDX_W-1:0] cfg_wr_index,
    input  logic [tvpa_pkg::CFG_W-1:0] cfg_wr_data,
    output tvpa_pkg::cfg_t            cfg
);
    import tvpa_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_RELATIVE_CONVENTION: cfg_next.relative_convention = cfg_wr_data[0];
                REG_FLOOR_FROM_SETTING:  cfg_next.floor_from_setting  = cfg_wr_data[0];
                REG_TARGET_VOLUME:       cfg_next.target_volume    = cfg_wr_data[VOL_W-1:0];
                REG_MAX_PRESSURE:        cfg_next.max_pressure     = cfg_wr_data[PRES_W-1:0];
                REG_PEEP_LEVEL:          cfg_next.peep_level       = cfg_wr_data[PRES_W-1:0];
                REG_PRESSURE_SETTING:    cfg_next.pressure_setting = cfg_wr_data[PRES_W-1:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.relative_convention <= 1'b0;
            cfg_reg.floor_from_setting  <= 1'b1;
            cfg_reg.target_volume       <= '0;
            cfg_reg.max_pressure        <= '0;
            cfg_reg.peep_level          <= '0;
            cfg_reg.pressure_setting    <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hw/rtl/tvpa_adjust.sv]
`include "assert_macros.svh"

module tvpa_adjust #(
    parameter int MIN_STEP = tvpa_pkg::MIN_STEP_DEF,
    parameter int MAX_STEP = tvpa_pkg::MAX_STEP_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      advance,
    input  tvpa_pkg::item_t           item,
    input  tvpa_pkg::cfg_t            cfg,
    output logic [tvpa_pkg::SP_W-1:0] set_point_next
);
    import tvpa_pkg::*;

    localparam int WIDE_W   = SP_W + 2;
    localparam int STEP_CAP = (MIN_STEP > MAX_STEP) ? MIN_STEP : MAX_STEP;
    // x / 5 == (x * 52429) >> 18 for every x below 2**18.
    localparam int RECIP5   = 52429;
    localparam int RECIP_SH = 18;
    localparam int X6_W     = VOL_W + 3;
    localparam int PROD_W   = X6_W + 16;

    logic [SP_W-1:0]   set_point_reg;
    logic              loaded_reg;
    logic [STEP_W-1:0] up_step_reg, up_step_next;
    logic [STEP_W-1:0] down_step_reg, down_step_next;
    logic              up_active_reg, up_active_next;
    logic              down_active_reg, down_active_next;

    logic [SP_W-1:0]         sp_base;
    logic [SP_W-1:0]         pmax;
    logic [SP_W-1:0]         pfloor;
    logic [X6_W-1:0]         target_x6;
    logic [PROD_W-1:0]       upper_prod;
    logic [VOL_W:0]          upper;
    logic [STEP_W:0]         up_dbl, down_dbl;
    logic [STEP_W-1:0]       up_cand, down_cand;
    logic signed [WIDE_W-1:0] sp_s, floor_s, pmax_s, v_s;

    // Upper edge of the volume band: target * 12 / 10, done as target * 6 / 5.
    assign target_x6  = X6_W'(cfg.target_volume) * X6_W'(6);
    assign upper_prod = PROD_W'(target_x6) * PROD_W'(RECIP5);
    assign upper      = upper_prod[RECIP_SH +: VOL_W+1];

    assign sp_base = (item.restart || !loaded_reg) ? {1'b0, cfg.pressure_setting}
                                                   : set_point_reg;
    assign pmax    = {1'b0, cfg.max_pressure}
                   + (cfg.relative_convention ? {1'b0, cfg.peep_level} : '0);
    assign pfloor  = cfg.floor_from_setting ? {1'b0, cfg.pressure_setting} : '0;

    assign sp_s    = $signed({2'b00, sp_base});
    assign floor_s = $signed({2'b00, pfloor});
    assign pmax_s  = $signed({2'b00, pmax});

    // Step sequence: first step is the minimum, then doubling up to the maximum.
    assign up_dbl    = {up_step_reg, 1'b0};
    assign down_dbl  = {down_step_reg, 1'b0};
    assign up_cand   = !up_active_reg ? STEP_W'(MIN_STEP)
                     : (up_dbl > (STEP_W+1)'(MAX_STEP)) ? STEP_W'(MAX_STEP)
                     : up_dbl[STEP_W-1:0];
    assign down_cand = !down_active_reg ? STEP_W'(MIN_STEP)
                     : (down_dbl > (STEP_W+1)'(MAX_STEP)) ? STEP_W'(MAX_STEP)
                     : down_dbl[STEP_W-1:0];

    always_comb begin
        up_step_next     = up_step_reg;
        down_step_next   = down_step_reg;
        up_active_next   = up_active_reg;
        down_active_next = down_active_reg;
        v_s              = sp_s;
        if (!item.high_pressure_alarm) begin
            if ({1'b0, item.measured_volume} > upper) begin
                up_active_next = 1'b0;
                if (sp_s > floor_s) begin
                    down_step_next   = down_cand;
                    down_active_next = 1'b1;
                    v_s = sp_s - $signed({{(WIDE_W-STEP_W){1'b0}}, down_cand});
                end
            end else if (item.measured_volume < cfg.target_volume) begin
                down_active_next = 1'b0;
                if (sp_s < pmax_s) begin
                    up_step_next   = up_cand;
                    up_active_next = 1'b1;
                    v_s = sp_s + $signed({{(WIDE_W-STEP_W){1'b0}}, up_cand});
                end
            end else begin
                down_active_next = 1'b0;
                up_active_next   = 1'b0;
            end
        end else begin
            // The alarm backs off the stored up step, whatever the last move was.
            down_active_next = 1'b0;
            up_active_next   = 1'b0;
            v_s = sp_s - $signed({{(WIDE_W-STEP_W){1'b0}}, up_step_reg});
        end

        if (v_s < floor_s) begin
            set_point_next = pfloor;
        end else if (v_s > pmax_s) begin
            set_point_next = pmax;
        end else begin
            set_point_next = v_s[SP_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_point_reg   <= '0;
            loaded_reg      <= 1'b0;
            up_step_reg     <= '0;
            down_step_reg   <= '0;
            up_active_reg   <= 1'b0;
            down_active_reg <= 1'b0;
        end else if (advance) begin
            set_point_reg   <= set_point_next;
            loaded_reg      <= 1'b1;
            up_step_reg     <= up_step_next;
            down_step_reg   <= down_step_next;
            up_active_reg   <= up_active_next;
            down_active_reg <= down_active_next;
        end
    end

    `ASSERT_ALWAYS(a_flags_exclusive, aclk, aresetn, !(up_active_reg && down_active_reg), "up and down sequences both active")
    `ASSERT_ALWAYS(a_step_bounded, aclk, aresetn, (up_step_reg <= STEP_W'(STEP_CAP)) && (down_step_reg <= STEP_W'(STEP_CAP)), "step beyond its cap")
    `ASSERT_NEXT(a_loaded_sticky, aclk, aresetn, loaded_reg, loaded_reg, "loaded flag dropped without reset")

endmodule

[hw/rtl/target_volume_pressure_adjuster_core.sv]
// Target-volume pressure adjuster.
// One word on the input channel (s_valid / s_ready) carries the measured
// inspired volume of a breath, the high-pressure alarm flag and a restart
// flag. For every accepted word the block delivers exactly one word on the
// result channel (m_valid / m_ready): the new clamped pressure set point.
// Configuration registers are written through cfg_wr_en, cfg_wr_index and
// cfg_wr_data, and must only be changed while no word is in flight.
// A word accepted on the input channel is latched in the input register, and
// its result is written to the result register when the word moves on.
// Throughput is one word per cycle unless the receiver stalls; the set point
// and step state are updated in the same cycle that the result is formed, so
// back-to-back words see the state left by their predecessor.
// When the receiver stalls, the result register holds its word and the input
// register still takes one more word; s_ready falls only when both are full.
// Reset clears the valid flags of both pipeline registers, the adjuster state
// (the first word after reset reloads the set point from the pressure
// setting) and the configuration registers to their reset values.
`include "assert_macros.svh"

module target_volume_pressure_adjuster_core #(
    parameter int MIN_STEP = tvpa_pkg::MIN_STEP_DEF,
    parameter int MAX_STEP = tvpa_pkg::MAX_STEP_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [tvpa_pkg::VOL_W-1:0] s_measured_volume,
    input  logic                       s_high_pressure_alarm,
    input  logic                       s_restart,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [tvpa_pkg::SP_W-1:0]  m_pressure_set_point,
    input  logic                       cfg_wr_en,
    input  logic [tvpa_pkg::IDX_W-1:0] cfg_wr_index,
    input  logic [tvpa_pkg::CFG_W-1:0] cfg_wr_data
);
    import tvpa_pkg::*;

    cfg_t            cfg;
    item_t           item_reg;
    logic            in_valid_reg;
    logic            out_valid_reg;
    logic [SP_W-1:0] out_sp_reg;
    logic [SP_W-1:0] set_point_next;
    logic            advance;
    logic            take_in;

    // A latched word moves on when the result register is empty or being emptied.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign take_in = s_valid && s_ready;

    tvpa_cfg_regs u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    tvpa_adjust #(
        .MIN_STEP (MIN_STEP),
        .MAX_STEP (MAX_STEP)
    ) u_adjust (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .advance        (advance),
        .item           (item_reg),
        .cfg            (cfg),
        .set_point_next (set_point_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (take_in) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (take_in) begin
            item_reg.measured_volume     <= s_measured_volume;
            item_reg.high_pressure_alarm <= s_high_pressure_alarm;
            item_reg.restart             <= s_restart;
        end
        if (advance) begin
            out_sp_reg <= set_point_next;
        end
    end

    assign m_valid              = out_valid_reg;
    assign m_pressure_set_point = out_sp_reg;

    `ASSERT_NEXT(a_advance_fills_out, aclk, aresetn, advance, out_valid_reg, "result register not filled after advance")
    `ASSERT_NEXT(a_stall_keeps_in, aclk, aresetn, in_valid_reg && out_valid_reg && !m_ready, in_valid_reg && $stable(item_reg), "latched word lost while stalled")
    `ASSERT_IMPLIES(a_ready_when_empty, aclk, aresetn, !in_valid_reg, s_ready, "input not ready while empty")

endmodule

[tb/target_volume_pressure_adjuster_core_tb.sv]
`timescale 1ns / 1ps

module target_volume_pressure_adjuster_core_tb;
    import tvpa_pkg::*;

    // Stop the run if this many cycles pass with no word moving on either channel
    // and no register write. The slowest correct run has the receiver refusing words
    // 87 percent of the time, so a gap this long cannot happen unless the block hangs.
    localparam int STALL_LIMIT = 4000;

    // The clock, reset and every block input start from known values.
    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic s_valid = 1'b0;
    logic s_ready;
    logic [VOL_W-1:0] s_measured_volume = '0;
    logic s_high_pressure_alarm = 1'b0;
    logic s_restart = 1'b0;

    logic m_valid;
    logic m_ready = 1'b0;
    logic [SP_W-1:0] m_pressure_set_point;

    logic cfg_wr_en = 1'b0;
    reg_idx_t cfg_wr_index = REG_RELATIVE_CONVENTION;
    logic [CFG_W-1:0] cfg_wr_data = '0;

    // Breaths waiting for the driver, and the set points that the accepted
    // breaths must produce, oldest first.
    item_t breath_queue[$];
    logic [SP_W-1:0] expected_set_points[$];

    // The share of cycles, in percent, in which the sender holds back a word and
    // the receiver refuses one. The stimulus process changes both between phases.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    int mismatch_count = 0;
    int stalled_cycles = 0;

    // Our own copy of the register file and of the adjuster state. The register
    // copy starts at the reset values: everything zero except floor_from_setting.
    cfg_t shadow_cfg = '{floor_from_setting: 1'b1, default: '0};
    logic [SP_W-1:0] sp_track = '0;
    logic sp_loaded = 1'b0;
    logic [STEP_W-1:0] up_step_track = '0;
    logic [STEP_W-1:0] down_step_track = '0;
    logic up_run = 1'b0;
    logic down_run = 1'b0;

    target_volume_pressure_adjuster_core dut (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_measured_volume     (s_measured_volume),
        .s_high_pressure_alarm (s_high_pressure_alarm),
        .s_restart             (s_restart),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_pressure_set_point  (m_pressure_set_point),
        .cfg_wr_en             (cfg_wr_en),
        .cfg_wr_index          (cfg_wr_index),
        .cfg_wr_data           (cfg_wr_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // The first step of a run in one direction is the minimum step, even when it
    // is larger than the maximum. Each repeat doubles the step and then saturates
    // at the maximum.
    function automatic logic [STEP_W-1:0] grow_step(input logic running,
                                                    input logic [STEP_W-1:0] step);
        int doubled;
        if (!running) begin
            return STEP_W'(MIN_STEP_DEF);
        end
        doubled = int'(step) * 2;
        if (doubled > MAX_STEP_DEF) begin
            doubled = MAX_STEP_DEF;
        end
        return STEP_W'(doubled);
    endfunction

    // Move the tracked set point for one breath and return the result that the
    // block must deliver for it. All arithmetic is done in signed 32-bit ints, so
    // a step that would take the set point below zero is caught by the clamp at
    // the floor and never wraps.
    function automatic logic [SP_W-1:0] adjust_set_point(input item_t breath);
        int vol;
        int pmax;
        int pfloor;
        int upper;
        int v;
        vol = int'(breath.measured_volume);
        pmax = int'(shadow_cfg.max_pressure);
        if (shadow_cfg.relative_convention) begin
            pmax += int'(shadow_cfg.peep_level);
        end
        // A restart, or the first breath after reset, reloads the set point. The
        // step values and the run flags are kept.
        if (breath.restart || !sp_loaded) begin
            sp_track = SP_W'(shadow_cfg.pressure_setting);
            sp_loaded = 1'b1;
        end
        pfloor = shadow_cfg.floor_from_setting ? int'(shadow_cfg.pressure_setting) : 0;
        upper = (int'(shadow_cfg.target_volume) * 12) / 10;
        v = int'(sp_track);
        if (breath.high_pressure_alarm) begin
            // The alarm takes the stored up step back off, whatever the last
            // move was, and ends both runs.
            down_run = 1'b0;
            up_run = 1'b0;
            v -= int'(up_step_track);
        end else if (vol > upper) begin
            up_run = 1'b0;
            if (v > pfloor) begin
                down_step_track = grow_step(down_run, down_step_track);
                down_run = 1'b1;
                v -= int'(down_step_track);
            end
        end else if (vol < int'(shadow_cfg.target_volume)) begin
            down_run = 1'b0;
            if (v < pmax) begin
                up_step_track = grow_step(up_run, up_step_track);
                up_run = 1'b1;
                v += int'(up_step_track);
            end
        end else begin
            down_run = 1'b0;
            up_run = 1'b0;
        end
        // A floor above the maximum wins only for values below the floor.
        if (v < pfloor) begin
            v = pfloor;
        end else if (v > pmax) begin
            v = pmax;
        end
        sp_track = v[SP_W-1:0];
        return sp_track;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // The driver. A word stays on the channel, unchanged, until it is taken; when
    // the slot is free the next breath goes out unless this cycle is an idle one.
    // Each accepted word is run through the predictor at the edge that takes it.
    always @(posedge aclk) begin : breath_driver
        item_t sent;
        item_t next_breath;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                sent.measured_volume = s_measured_volume;
                sent.high_pressure_alarm = s_high_pressure_alarm;
                sent.restart = s_restart;
                expected_set_points.push_back(adjust_set_point(sent));
            end
            if (!s_valid || s_ready) begin
                if (breath_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_breath = breath_queue.pop_front();
                    s_valid <= 1'b1;
                    s_measured_volume <= next_breath.measured_volume;
                    s_high_pressure_alarm <= next_breath.high_pressure_alarm;
                    s_restart <= next_breath.restart;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // The monitor. It stalls the result channel at random and checks every
    // accepted word against the oldest predicted set point.
    always @(posedge aclk) begin : set_point_monitor
        logic [SP_W-1:0] want;
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (aresetn && m_valid && m_ready) begin
            if (expected_set_points.size() == 0) begin
                report_mismatch($sformatf("set point %0d arrived with no breath pending",
                                          m_pressure_set_point));
            end else begin
                want = expected_set_points.pop_front();
                if (m_pressure_set_point !== want) begin
                    report_mismatch($sformatf("pressure_set_point is %0d, predicted %0d",
                                              m_pressure_set_point, want));
                end
            end
        end
    end

    // The watchdog. Any word moved or register written restarts the count.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            stalled_cycles = 0;
        end else begin
            stalled_cycles++;
        end
        if (stalled_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Drive one register write and update our copy of the register. Registers are
    // only written while nothing is in flight, so the copy can change at once.
    task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= value;
        case (idx)
            REG_RELATIVE_CONVENTION: shadow_cfg.relative_convention = value[0];
            REG_FLOOR_FROM_SETTING:  shadow_cfg.floor_from_setting = value[0];
            REG_TARGET_VOLUME:       shadow_cfg.target_volume = value[VOL_W-1:0];
            REG_MAX_PRESSURE:        shadow_cfg.max_pressure = value[PRES_W-1:0];
            REG_PEEP_LEVEL:          shadow_cfg.peep_level = value[PRES_W-1:0];
            REG_PRESSURE_SETTING:    shadow_cfg.pressure_setting = value[PRES_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input int relative, input int floor_sel, input int target,
                                 input int pmax, input int peep, input int setting);
        write_reg(REG_RELATIVE_CONVENTION, CFG_W'(relative));
        write_reg(REG_FLOOR_FROM_SETTING, CFG_W'(floor_sel));
        write_reg(REG_TARGET_VOLUME, CFG_W'(target));
        write_reg(REG_MAX_PRESSURE, CFG_W'(pmax));
        write_reg(REG_PEEP_LEVEL, CFG_W'(peep));
        write_reg(REG_PRESSURE_SETTING, CFG_W'(setting));
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic push_breath(input int vol, input bit alarm, input bit restart);
        item_t breath;
        breath.measured_volume = VOL_W'(vol);
        breath.high_pressure_alarm = alarm;
        breath.restart = restart;
        breath_queue.push_back(breath);
    endtask

    // Random breaths. Most follow a trend (below target, in band, above band) that
    // holds for a few breaths, so the steps get to double and saturate; now and
    // then the volume lands right on a band edge. The rest are volumes from the
    // whole range. Alarms and restarts are mixed in at a low rate.
    task automatic queue_random_breaths(input int count);
        int trend;
        int tgt;
        int top;
        int vol;
        bit on_edge;
        trend = 0;
        tgt = int'(shadow_cfg.target_volume);
        top = (tgt * 12) / 10;
        repeat (count) begin
            if ($urandom_range(3) == 0) begin
                trend = $urandom_range(2);
            end
            on_edge = ($urandom_range(7) == 0);
            vol = $urandom_range(4095);
            if ($urandom_range(9) != 0) begin
                case (trend)
                    0: if (tgt > 0) begin
                        vol = on_edge ? tgt - 1 : $urandom_range(tgt - 1, 0);
                    end
                    1: begin
                        if (top > 4095) begin
                            top = 4095;
                        end
                        if (on_edge) begin
                            vol = $urandom_range(1) ? tgt : top;
                        end else begin
                            vol = $urandom_range(top, tgt);
                        end
                        top = (tgt * 12) / 10;
                    end
                    default: if (top < 4095) begin
                        vol = on_edge ? top + 1 : $urandom_range(4095, top + 1);
                    end
                endcase
            end
            push_breath(vol, $urandom_range(99) < 8, $urandom_range(99) < 4);
        end
    endtask

    // Let every queued breath go out and every result come back, then let the
    // clock run on so the pipeline is surely empty before registers change.
    task automatic wait_drained();
        do begin
            @(negedge aclk);
        end while (breath_queue.size() != 0 || s_valid || expected_set_points.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    initial begin : stimulus
        int phase;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Two breaths with the registers still at their reset values. The first
        // one loads the set point because nothing has been loaded yet.
        send_idle_pct = 26;
        recv_stall_pct = 87;
        push_breath(0, 1'b0, 1'b0);
        push_breath(4095, 1'b1, 1'b1);
        wait_drained();

        for (phase = 0; phase < 6; phase++) begin
            // Sender idles lightly and receiver heavily first, then the reverse,
            // then both run flat out.
            send_idle_pct = (phase < 2) ? 26 : (phase < 4) ? 87 : 0;
            recv_stall_pct = (phase < 2) ? 87 : (phase < 4) ? 26 : 0;
            case (phase)
                0: apply_setting(0, 1, 500, 60, 0, 20);
                // Relative maximum at its highest, floor at zero, target at its top
                // so the volume can never exceed the band.
                1: apply_setting(1, 0, 4095, 1023, 1023, 1023);
                // Everything at zero: any nonzero volume is above the band.
                2: apply_setting(0, 0, 0, 0, 0, 0);
                // Floor (200) above the relative maximum (150).
                3: apply_setting(1, 1, 300, 100, 50, 200);
                4: apply_setting($urandom_range(1), $urandom_range(1), $urandom_range(4095),
                                 $urandom_range(1023), $urandom_range(1023),
                                 $urandom_range(1023));
                // Band tops out at 4094, so only the largest volume is above it.
                default: apply_setting(1, 0, 3412, 500, 7, 1);
            endcase
            if (phase == 0) begin
                // Climb from the floor with doubling steps into the maximum, then
                // hold there since no up step is taken at the maximum.
                repeat (6) push_breath(0, 1'b0, 1'b0);
                // Fall back down into the floor the same way and hold there.
                repeat (6) push_breath(4095, 1'b0, 1'b0);
                // Both band edges, one past each edge.
                push_breath(500, 1'b0, 1'b0);
                push_breath(600, 1'b0, 1'b0);
                push_breath(601, 1'b0, 1'b0);
                push_breath(499, 1'b0, 1'b0);
                // Alarm on a low and on a high volume, restart alone, restart
                // together with the alarm, and all flags at once.
                push_breath(0, 1'b1, 1'b0);
                push_breath(4095, 1'b1, 1'b0);
                push_breath(600, 1'b0, 1'b1);
                push_breath(0, 1'b1, 1'b1);
                push_breath(4095, 1'b1, 1'b1);
            end
            queue_random_breaths(85);
            wait_drained();
        end

        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
